/* sv/running_median_filter_defines.svh */
// assertion helpers used by the running median filter sources
`ifndef RUNNING_MEDIAN_FILTER_DEFINES_SVH
`define RUNNING_MEDIAN_FILTER_DEFINES_SVH

// invariant that must hold at every clock edge outside reset
`define RMF_CHECK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// condition that must hold in the cycle after a trigger
`define RMF_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rmf_pkg.sv */
package rmf_pkg;

  // age tags cover every cell of the largest supported chain
  localparam int AGE_W = 6;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               start_of_seq;
    logic               end_of_seq;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] median;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] val;
    logic [AGE_W-1:0]   age;
  } cell_state_t;

  // what a cell offers its neighbours: value, age after this shift, value <= new sample
  typedef struct packed {
    logic signed [15:0] val;
    logic [AGE_W-1:0]   age;
    logic               le;
  } cell_bus_t;

endpackage

/* sv/rmf_cell.sv */
module rmf_cell #(
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic signed [15:0]  sample,
  input  logic [3:0]          win_len,
  input  rmf_pkg::cell_bus_t  left,
  input  rmf_pkg::cell_bus_t  right,
  input  logic                rb_in,
  output logic                rb_out,
  output rmf_pkg::cell_bus_t  bus,
  output rmf_pkg::cell_state_t cur
);
  import rmf_pkg::*;

  logic [AGE_W-1:0] age_lim;
  logic             del;
  cell_bus_t        ck;
  cell_bus_t        ckm1;
  cell_state_t      cur_next;

  assign age_lim = AGE_W'(win_len);
  // the oldest window entry leaves on this shift
  assign del     = (cur.age == '0);
  assign rb_out  = rb_in | del;

  always_comb begin
    bus.val = cur.val;
    bus.le  = (cur.val <= sample);
    if (!del && (cur.age < age_lim)) begin
      bus.age = cur.age - AGE_W'(1);
    end else begin
      bus.age = cur.age;
    end
  end

  // entries k and k-1 of the chain once the oldest one has been taken out
  assign ck   = rb_out ? right : bus;
  assign ckm1 = rb_in ? bus : left;

  always_comb begin
    if (ck.le) begin
      cur_next.val = ck.val;
      cur_next.age = ck.age;
    end else if (ckm1.le) begin
      cur_next.val = sample;
      cur_next.age = AGE_W'(win_len - 4'd1);
    end else begin
      cur_next.val = ckm1.val;
      cur_next.age = ckm1.age;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.val <= '0;
      cur.age <= AGE_W'(INDEX);
    end else if (shift) begin
      cur <= cur_next;
    end
  end

endmodule

/* sv/rmf_select.sv */
module rmf_select #(
  parameter int MAX_WINDOW = 15
) (
  input  rmf_pkg::cell_state_t cells [MAX_WINDOW],
  input  logic [MAX_WINDOW-1:0] active,
  input  logic [2:0]            half,
  output logic signed [15:0]    median
);
  import rmf_pkg::*;

  // the active cell with exactly half active cells below it in the sorted chain
  always_comb begin
    median = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      if (active[k] &&
          ($countones(active & ~({MAX_WINDOW{1'b1}} << k)) == int'(half))) begin
        median = median | cells[k].val;
      end
    end
  end

endmodule

/* sv/running_median_filter.sv */
// Sliding-window median over signed 16-bit samples. The window lives in a chain of
// MAX_WINDOW cells kept in ascending order, each cell tagged with the age of its entry;
// one cycle shifts one sample in (the oldest entry leaves, the new one drops into its
// sorted place) and the median is read from the chain once that shift is registered. An
// item is taken, a start item then refills the window by shifting its sample in, the
// item's sample is shifted in once more, and an end item then runs flush shifts with
// its sample replicated; a median is read out after the main shift once enough of the
// run has gone in, and after each flush shift; readout waits while the output stalls.
// The next item is taken once the previous one has been fully worked off.
`include "running_median_filter_defines.svh"

module running_median_filter #(
  parameter int MAX_WINDOW = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rmf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rmf_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data
);
  import rmf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam cell_bus_t LEFT_EDGE  = '{val: '0, age: '0, le: 1'b1};
  localparam cell_bus_t RIGHT_EDGE = '{val: '0, age: '0, le: 1'b0};

  logic [1:0]         state;
  logic [3:0]         window_len;
  logic [3:0]         n_eff;
  logic [2:0]         half;
  logic [2:0]         pos;
  logic [2:0]         pos_base;
  logic [3:0]         fill_left;
  logic               main_pending;
  logic               main_emit;
  logic [2:0]         flush_left;
  logic               end_flag;
  logic               emit_last;
  logic signed [15:0] s_hold;
  logic               accept;
  logic               shift;
  logic               slot_free;
  logic               load_out;
  logic signed [15:0] median;

  cell_bus_t             bus       [MAX_WINDOW];
  cell_bus_t             left_bus  [MAX_WINDOW];
  cell_bus_t             right_bus [MAX_WINDOW];
  cell_state_t           cells     [MAX_WINDOW];
  logic [MAX_WINDOW:0]   rb;
  logic [MAX_WINDOW-1:0] active;
  logic [MAX_WINDOW-1:0] oldest;

  always_comb begin
    if (window_len == 4'd0) begin
      n_eff = 4'd1;
    end else if (int'(window_len) > MAX_WINDOW) begin
      n_eff = 4'(MAX_WINDOW);
    end else begin
      n_eff = window_len;
    end
  end

  assign half      = n_eff[3:1];
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign shift     = (state == ST_RUN);
  assign slot_free = !out_valid || !out_stall;
  assign load_out  = (state == ST_EMIT) && slot_free;
  assign pos_base  = in_data.start_of_seq ? 3'd0 : pos;

  // cell chain
  assign rb[0] = 1'b0;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_lo
      assign left_bus[k] = LEFT_EDGE;
    end else begin : g_lo
      assign left_bus[k] = bus[k-1];
    end
    if (k == MAX_WINDOW - 1) begin : g_hi
      assign right_bus[k] = RIGHT_EDGE;
    end else begin : g_hi
      assign right_bus[k] = bus[k+1];
    end

    assign active[k] = (cells[k].age < AGE_W'(n_eff));
    assign oldest[k] = (cells[k].age == '0);

    rmf_cell #(
      .INDEX (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .sample  (s_hold),
      .win_len (n_eff),
      .left    (left_bus[k]),
      .right   (right_bus[k]),
      .rb_in   (rb[k]),
      .rb_out  (rb[k+1]),
      .bus     (bus[k]),
      .cur     (cells[k])
    );
  end

  rmf_select #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_select (
    .cells  (cells),
    .active (active),
    .half   (half),
    .median (median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= 4'd3;
    end else if (cfg_wr_en) begin
      window_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pos          <= 3'd0;
      fill_left    <= 4'd0;
      main_pending <= 1'b0;
      main_emit    <= 1'b0;
      flush_left   <= 3'd0;
      end_flag     <= 1'b0;
      emit_last    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            s_hold       <= in_data.sample;
            fill_left    <= in_data.start_of_seq ? n_eff : 4'd0;
            main_pending <= 1'b1;
            main_emit    <= (pos_base >= half);
            flush_left   <= in_data.end_of_seq ? half : 3'd0;
            end_flag     <= in_data.end_of_seq;
            if (in_data.end_of_seq) begin
              pos <= 3'd0;
            end else if (pos_base < half) begin
              pos <= pos_base + 3'd1;
            end else begin
              pos <= half;
            end
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (fill_left != 4'd0) begin
            fill_left <= fill_left - 4'd1;
          end else if (main_pending) begin
            main_pending <= 1'b0;
            if (main_emit) begin
              emit_last <= end_flag && (half == 3'd0);
              state     <= ST_EMIT;
            end else if (flush_left == 3'd0) begin
              state <= ST_IDLE;
            end
          end else begin
            // flush step with the last sample replicated
            flush_left <= flush_left - 3'd1;
            emit_last  <= (flush_left == 3'd1);
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_data.median      <= median;
            out_data.last_of_run <= emit_last;
            state                <= (flush_left != 3'd0) ? ST_RUN : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `RMF_CHECK(a_one_oldest, $onehot(oldest), "age tags lost the single oldest entry")
  `RMF_CHECK(a_oldest_seen, rb[MAX_WINDOW], "removal chain found no oldest entry")
  `RMF_CHECK(a_window_fill, $countones(active) == int'(n_eff), "active cells off length")
  `RMF_CHECK_NEXT(a_item_works, accept, state == ST_RUN, "accepted item did not start shifting")

endmodule
